FILE: hw/rtl/cpl_pkg.sv
// ----------------------------------------------------------------------------
// cpl_pkg
// shared types and constants for the class-priority lru victim selector
// ----------------------------------------------------------------------------
package cpl_pkg;

  localparam int unsigned SET_W  = 6;
  localparam int unsigned WAY_W  = 3;
  localparam int unsigned TIME_W = 64;

  // command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // request codes on the input channel
  localparam logic REQ_TOUCH = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_TOUCH,
    OP_QUERY,
    OP_QUERY_MISS
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e             op;
    logic [SET_W-1:0]    set_idx;
    logic [WAY_W-1:0]    way_idx;
    logic [TIME_W-1:0]   stamp;
    logic                gpu;
  } cmd_t;

  // one way of one set as stored
  typedef struct packed {
    logic              gpu;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN
  } back_state_e;

  typedef struct packed {
    logic clearing;
    logic scanning;
  } bk_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hw/rtl/class_priority_lru_victim_select.sv
// ----------------------------------------------------------------------------
// class_priority_lru_victim_select
// lru replacement with gpu-class priority for a set-associative store
// ----------------------------------------------------------------------------
// Each way of each set holds a 64-bit last-use stamp and a gpu class flag.
// A touch (req_type 0) records stamp and class for one set and way and
// returns nothing; touches to a set or way beyond NUM_SETS / NUM_WAYS are
// taken and dropped. A query (req_type 1) returns one transfer: the oldest
// gpu-class way of the set if the set has one, else the oldest cpu-class
// way, lowest way on equal stamps; a query to a set beyond NUM_SETS returns
// way 0, cpu class. The front takes one transfer per cycle into a
// two-entry command queue while that queue has room. The back retires a
// touch with a single way write into the set memory, and a query by first
// reading the set row into a register, then one way per cycle through a
// single 65-bit compare of {not gpu, stamp}; it takes no new command while
// a query scans. After reset the back clears the set memory, one set per
// cycle, and in_ready_o stays low until that pass ends.
// ----------------------------------------------------------------------------
module class_priority_lru_victim_select #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned NUM_WAYS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [cpl_pkg::SET_W-1:0]   set_index_i,
  input  logic [cpl_pkg::WAY_W-1:0]   way_index_i,
  input  logic [cpl_pkg::TIME_W-1:0]  access_time_i,
  input  logic                        from_gpu_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cpl_pkg::WAY_W-1:0]   victim_way_o,
  output logic                        victim_is_gpu_o
);

  // front to queue
  logic              push;
  cpl_pkg::cmd_t     push_cmd;

  // queue to back
  logic              pop;
  cpl_pkg::cmd_t     head;
  cpl_pkg::q_stat_t  q_stat;

  // back status, clearing gates the front
  cpl_pkg::bk_stat_t bk_stat;

  cpl_front #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .set_index_i   (set_index_i),
    .way_index_i   (way_index_i),
    .access_time_i (access_time_i),
    .from_gpu_i    (from_gpu_i),
    .clearing_i    (bk_stat.clearing),
    .q_full_i      (q_stat.full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  cpl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  cpl_back #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .q_empty_i       (q_stat.empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .victim_way_o    (victim_way_o),
    .victim_is_gpu_o (victim_is_gpu_o),
    .stat_o          (bk_stat)
  );

  // a scan starts only once the result register is free, so nothing waits
  // on the output while a row is being scanned
  a_scan_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.scanning |-> !out_valid_o)
    else $error("result pending during victim scan");

  // no transfer is taken while the set memory is being cleared
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.clearing |-> !(in_valid_i && in_ready_o))
    else $error("input transfer during clearing pass");

  // queue occupancy stays consistent
  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !q_stat.empty)
    else $error("command queue both full and empty");

endmodule

FILE: hw/rtl/cpl_front.sv
// ----------------------------------------------------------------------------
// cpl_front
// accepts items, drops touches that address nothing, tags queries
// ----------------------------------------------------------------------------
module cpl_front #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned NUM_WAYS = 8
) (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [cpl_pkg::SET_W-1:0]    set_index_i,
  input  logic [cpl_pkg::WAY_W-1:0]    way_index_i,
  input  logic [cpl_pkg::TIME_W-1:0]   access_time_i,
  input  logic                         from_gpu_i,
  input  logic                         clearing_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output cpl_pkg::cmd_t                cmd_o
);

  logic set_ok;
  logic way_ok;
  logic keep;

  assign set_ok = 32'(set_index_i) < NUM_SETS;
  assign way_ok = 32'(way_index_i) < NUM_WAYS;

  // touches out of range are taken and dropped
  assign keep = (req_type_i == cpl_pkg::REQ_QUERY) || (set_ok && way_ok);

  assign in_ready_o = !q_full_i && !clearing_i;
  assign push_o     = in_valid_i && in_ready_o && keep;

  always_comb begin
    cmd_o.set_idx = set_index_i;
    cmd_o.way_idx = way_index_i;
    cmd_o.stamp   = access_time_i;
    cmd_o.gpu     = from_gpu_i;
    if (req_type_i == cpl_pkg::REQ_TOUCH) begin
      cmd_o.op = cpl_pkg::OP_TOUCH;
    end else if (set_ok) begin
      cmd_o.op = cpl_pkg::OP_QUERY;
    end else begin
      cmd_o.op = cpl_pkg::OP_QUERY_MISS;
    end
  end

endmodule

FILE: hw/rtl/cpl_queue.sv
// ----------------------------------------------------------------------------
// cpl_queue
// short command fifo that decouples the front from the back
// ----------------------------------------------------------------------------
module cpl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cpl_pkg::cmd_t     cmd_i,
  input  logic              pop_i,
  output cpl_pkg::cmd_t     head_o,
  output cpl_pkg::q_stat_t  stat_o
);

  cpl_pkg::cmd_t                  q_q [cpl_pkg::QDEPTH];
  logic [cpl_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [cpl_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [cpl_pkg::QPTR_W:0]       cnt_q, cnt_d;
  logic                           do_push;
  logic                           do_pop;

  assign stat_o.full  = cnt_q == (cpl_pkg::QPTR_W + 1)'(cpl_pkg::QDEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = q_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hw/rtl/cpl_back.sv
// ----------------------------------------------------------------------------
// cpl_back
// per-set way memory, touch writes, victim scan and result register
// ----------------------------------------------------------------------------
module cpl_back #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned NUM_WAYS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cpl_pkg::cmd_t               head_i,
  input  logic                        q_empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cpl_pkg::WAY_W-1:0]   victim_way_o,
  output logic                        victim_is_gpu_o,
  output cpl_pkg::bk_stat_t           stat_o
);

  localparam int unsigned SET_IW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WAY_IW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned KEY_W  = cpl_pkg::TIME_W + 1;

  cpl_pkg::back_state_e state_q, state_d;

  cpl_pkg::entry_t mem_q [NUM_SETS][NUM_WAYS];
  cpl_pkg::entry_t row_q [NUM_WAYS];

  logic [NUM_WAYS-1:0]         mem_wen;
  logic [SET_IW-1:0]           mem_widx;
  cpl_pkg::entry_t             mem_wdata;
  logic                        mem_ren;

  logic [SET_IW-1:0]           clr_q, clr_d;
  logic [WAY_IW-1:0]           cnt_q, cnt_d;
  logic                        found_q, found_d;
  logic [KEY_W-1:0]            best_key_q, best_key_d;
  logic [WAY_IW-1:0]           best_way_q, best_way_d;

  logic                        res_valid_q, res_valid_d;
  logic [cpl_pkg::WAY_W-1:0]   res_way_q, res_way_d;
  logic                        res_gpu_q, res_gpu_d;

  logic [SET_IW+cpl_pkg::SET_W-1:0] set_ext;
  logic [SET_IW-1:0]                head_set;
  logic [WAY_IW+cpl_pkg::WAY_W-1:0] way_ext;
  logic [WAY_IW-1:0]                head_way;

  logic                        out_free;
  logic                        clr_last;
  logic                        scan_last;
  cpl_pkg::entry_t             cur;
  logic [KEY_W-1:0]            cur_key;
  logic                        take;
  logic [WAY_IW-1:0]           final_way;
  logic                        final_gpu;
  logic [WAY_IW+cpl_pkg::WAY_W-1:0] fway_ext;
  logic                        load_miss;
  logic                        load_scan;

  assign set_ext  = {{SET_IW{1'b0}}, head_i.set_idx};
  assign head_set = set_ext[SET_IW-1:0];
  assign way_ext  = {{WAY_IW{1'b0}}, head_i.way_idx};
  assign head_way = way_ext[WAY_IW-1:0];

  assign out_free  = !res_valid_q || out_ready_i;
  assign clr_last  = clr_q == SET_IW'(NUM_SETS - 1);
  assign scan_last = cnt_q == WAY_IW'(NUM_WAYS - 1);

  // gpu ways sort below cpu ways, then by stamp
  assign cur      = row_q[cnt_q];
  assign cur_key  = {!cur.gpu, cur.stamp};
  assign take     = !found_q || (cur_key < best_key_q);
  assign final_way = take ? cnt_q : best_way_q;
  assign final_gpu = take ? cur.gpu : !best_key_q[KEY_W-1];
  assign fway_ext  = {{cpl_pkg::WAY_W{1'b0}}, final_way};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpl_pkg::BK_CLEAR: begin
        if (clr_last) begin
          state_d = cpl_pkg::BK_IDLE;
        end
      end
      cpl_pkg::BK_IDLE: begin
        if (pop_o && head_i.op == cpl_pkg::OP_QUERY) begin
          state_d = cpl_pkg::BK_SCAN;
        end
      end
      cpl_pkg::BK_SCAN: begin
        if (scan_last) begin
          state_d = cpl_pkg::BK_IDLE;
        end
      end
      default: state_d = cpl_pkg::BK_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o     = 1'b0;
    mem_wen   = '0;
    mem_widx  = head_set;
    mem_wdata = '{gpu: head_i.gpu, stamp: head_i.stamp};
    mem_ren   = 1'b0;
    load_miss = 1'b0;
    load_scan = 1'b0;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    stat_o.clearing = 1'b0;
    stat_o.scanning = 1'b0;
    case (state_q)
      cpl_pkg::BK_CLEAR: begin
        stat_o.clearing = 1'b1;
        mem_wen   = '1;
        mem_widx  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      cpl_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          case (head_i.op)
            cpl_pkg::OP_TOUCH: begin
              pop_o = 1'b1;
              for (int w = 0; w < NUM_WAYS; w++) begin
                mem_wen[w] = head_way == WAY_IW'(w);
              end
            end
            cpl_pkg::OP_QUERY: begin
              if (out_free) begin
                pop_o   = 1'b1;
                mem_ren = 1'b1;
                cnt_d   = '0;
              end
            end
            cpl_pkg::OP_QUERY_MISS: begin
              if (out_free) begin
                pop_o     = 1'b1;
                load_miss = 1'b1;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      cpl_pkg::BK_SCAN: begin
        stat_o.scanning = 1'b1;
        cnt_d = cnt_q + 1'b1;
        load_scan = scan_last;
      end
      default: ;
    endcase
  end

  // running minimum over the row
  always_comb begin
    found_d    = found_q;
    best_key_d = best_key_q;
    best_way_d = best_way_q;
    if (mem_ren) begin
      found_d = 1'b0;
    end else if (state_q == cpl_pkg::BK_SCAN && take) begin
      found_d    = 1'b1;
      best_key_d = cur_key;
      best_way_d = cnt_q;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    res_way_d   = res_way_q;
    res_gpu_d   = res_gpu_q;
    if (load_miss) begin
      res_valid_d = 1'b1;
      res_way_d   = '0;
      res_gpu_d   = 1'b0;
    end else if (load_scan) begin
      res_valid_d = 1'b1;
      res_way_d   = fway_ext[cpl_pkg::WAY_W-1:0];
      res_gpu_d   = final_gpu;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpl_pkg::BK_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_key_q <= best_key_d;
    best_way_q <= best_way_d;
    res_way_q  <= res_way_d;
    res_gpu_q  <= res_gpu_d;
  end

  // way memory: per-way write enables, one registered row read
  always_ff @(posedge clk_i) begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (mem_wen[w]) begin
        mem_q[mem_widx][w] <= mem_wdata;
      end
    end
    if (mem_ren) begin
      row_q <= mem_q[head_set];
    end
  end

  assign out_valid_o     = res_valid_q;
  assign victim_way_o    = res_way_q;
  assign victim_is_gpu_o = res_gpu_q;

endmodule
